// ===== rtl/core/rqwa_pkg.sv =====
// Shared types and codes for the ring queue with wait aging.
// Used by the top, front end, back end and checker; depends on nothing.
`timescale 1ns / 1ps

package rqwa_pkg;

  localparam int unsigned ClientW = 16;
  localparam int unsigned WaitW   = 32;
  localparam int unsigned CountW  = 4;

  // Request codes on the mode field; the fourth code means nothing.
  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_DEQ = 2'd1;
  localparam logic [1:0] MODE_ADD = 2'd2;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_ADD,
    OP_FAIL
  } op_e;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              full;
    logic              empty;
  } status_t;

  typedef struct packed {
    op_e                op;
    status_t            status;
    logic [ClientW-1:0] client;
    logic [WaitW-1:0]   amount;
  } cmd_t;

endpackage

// ===== rtl/core/ring_queue_with_wait_aging_top.sv =====
// Top level of the ring queue with wait aging: front end, command queue
// and back end. Depends on rqwa_pkg, rqwa_front, rqwa_cmd_fifo, rqwa_back.
`timescale 1ns / 1ps

// Queue of up to QUEUE_SLOTS-1 clients, each with a 16.16 wait that wraps
// modulo 2^32. Every request beat (enqueue, dequeue, age all) yields one result
// beat, in order. The block takes one request per cycle and returns one result
// per cycle when the output side keeps up; a request's classified command is
// written into the two-entry command queue, then the back end reads the slot
// memory and finally loads the result register. The slot memory's single port
// and the one-command-per-cycle back end set that rate. Ageing is a single
// addition, as waits are kept as offsets against a running time base. No
// clearing pass is needed after reset.
module ring_queue_with_wait_aging_top #(
  parameter int unsigned QUEUE_SLOTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic [rqwa_pkg::ClientW-1:0] client_id_i,
  input  logic [rqwa_pkg::WaitW-1:0]   amount_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         ok_o,
  output logic [rqwa_pkg::ClientW-1:0] out_client_id_o,
  output logic [rqwa_pkg::WaitW-1:0]   out_wait_o,
  output logic [rqwa_pkg::CountW-1:0]  count_o,
  output logic                         is_full_o,
  output logic                         is_empty_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_SLOTS);
  localparam int unsigned BeatW = $bits(rqwa_pkg::cmd_t) + IdxW;

  logic             fq_valid, fq_ready;
  rqwa_pkg::cmd_t   f_cmd;
  logic [IdxW-1:0]  f_addr;
  logic             bq_valid, bq_ready;
  rqwa_pkg::cmd_t   b_cmd;
  logic [IdxW-1:0]  b_addr;
  logic [BeatW-1:0] q_wr, q_rd;

  rqwa_front #(
    .QUEUE_SLOTS(QUEUE_SLOTS),
    .IDX_W      (IdxW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .client_id_i(client_id_i),
    .amount_i   (amount_i),
    .cmd_ready_i(fq_ready),
    .cmd_valid_o(fq_valid),
    .cmd_o      (f_cmd),
    .cmd_addr_o (f_addr)
  );

  assign q_wr = {f_cmd, f_addr};

  rqwa_cmd_fifo #(
    .WIDTH(BeatW)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fq_valid),
    .wr_ready_o(fq_ready),
    .wr_data_i (q_wr),
    .rd_valid_o(bq_valid),
    .rd_ready_i(bq_ready),
    .rd_data_o (q_rd)
  );

  assign b_cmd  = rqwa_pkg::cmd_t'(q_rd[BeatW-1:IdxW]);
  assign b_addr = q_rd[IdxW-1:0];

  rqwa_back #(
    .QUEUE_SLOTS(QUEUE_SLOTS),
    .IDX_W      (IdxW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (bq_valid),
    .cmd_ready_o    (bq_ready),
    .cmd_i          (b_cmd),
    .cmd_addr_i     (b_addr),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ok_o           (ok_o),
    .out_client_id_o(out_client_id_o),
    .out_wait_o     (out_wait_o),
    .count_o        (count_o),
    .is_full_o      (is_full_o),
    .is_empty_o     (is_empty_o)
  );

endmodule

// ===== rtl/core/rqwa_front.sv =====
// Front end: takes request beats, keeps head, tail and fill, classifies each
// request and issues a command. Depends on rqwa_pkg.
`timescale 1ns / 1ps

module rqwa_front #(
  parameter int unsigned QUEUE_SLOTS = 16,
  parameter int unsigned IDX_W       = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic [rqwa_pkg::ClientW-1:0] client_id_i,
  input  logic [rqwa_pkg::WaitW-1:0]   amount_i,
  input  logic                         cmd_ready_i,
  output logic                         cmd_valid_o,
  output rqwa_pkg::cmd_t               cmd_o,
  output logic [IDX_W-1:0]             cmd_addr_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(QUEUE_SLOTS - 1);

  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [IDX_W-1:0] fill_q, fill_d;
  logic [IDX_W+rqwa_pkg::CountW-1:0] fill_ext;
  rqwa_pkg::op_e op;
  logic accept;
  logic full, empty;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i && cmd_ready_i;

  assign full  = (fill_q == LastIdx);
  assign empty = (fill_q == '0);

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    cmd_addr_o = head_q;
    unique case (mode_i)
      rqwa_pkg::MODE_ENQ: begin
        cmd_addr_o = tail_q;
        if (!full) begin
          op     = rqwa_pkg::OP_ENQ;
          tail_d = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
          fill_d = fill_q + 1'b1;
        end else begin
          op = rqwa_pkg::OP_FAIL;
        end
      end
      rqwa_pkg::MODE_DEQ: begin
        if (!empty) begin
          op     = rqwa_pkg::OP_DEQ;
          head_d = (head_q == LastIdx) ? '0 : head_q + 1'b1;
          fill_d = fill_q - 1'b1;
        end else begin
          op = rqwa_pkg::OP_FAIL;
        end
      end
      rqwa_pkg::MODE_ADD: begin
        op = empty ? rqwa_pkg::OP_FAIL : rqwa_pkg::OP_ADD;
      end
      default: begin
        op = rqwa_pkg::OP_FAIL;
      end
    endcase
  end

  // Fill after the request, reported modulo 16.
  assign fill_ext = {{rqwa_pkg::CountW{1'b0}}, fill_d};

  always_comb begin
    cmd_o.op           = op;
    cmd_o.status.count = fill_ext[rqwa_pkg::CountW-1:0];
    cmd_o.status.full  = (fill_d == LastIdx);
    cmd_o.status.empty = (fill_d == '0);
    cmd_o.client       = client_id_i;
    cmd_o.amount       = amount_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else if (accept) begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

endmodule

// ===== rtl/core/rqwa_cmd_fifo.sv =====
// Two-entry command queue between front and back end.
// Generic payload width; no package dependency.
`timescale 1ns / 1ps

module rqwa_cmd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] buf_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       used_q;
  logic             push, pop;

  assign wr_ready_o = (used_q != 2'd2);
  assign rd_valid_o = (used_q != 2'd0);
  assign rd_data_o  = buf_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      used_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        used_q <= used_q + 2'd1;
      end else if (pop && !push) begin
        used_q <= used_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/rqwa_back.sv =====
// Back end: slot memory, running time base and result register.
// Waits are stored relative to the time base. Depends on rqwa_pkg.
`timescale 1ns / 1ps

module rqwa_back #(
  parameter int unsigned QUEUE_SLOTS = 16,
  parameter int unsigned IDX_W       = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  rqwa_pkg::cmd_t               cmd_i,
  input  logic [IDX_W-1:0]             cmd_addr_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         ok_o,
  output logic [rqwa_pkg::ClientW-1:0] out_client_id_o,
  output logic [rqwa_pkg::WaitW-1:0]   out_wait_o,
  output logic [rqwa_pkg::CountW-1:0]  count_o,
  output logic                         is_full_o,
  output logic                         is_empty_o
);

  localparam int unsigned EntryW = rqwa_pkg::ClientW + rqwa_pkg::WaitW;

  logic [EntryW-1:0]          slot_q [QUEUE_SLOTS];
  logic [EntryW-1:0]          rd_q;
  logic [rqwa_pkg::WaitW-1:0] base_q;
  logic [rqwa_pkg::WaitW-1:0] s1_base_q;
  rqwa_pkg::op_e              s1_op_q;
  rqwa_pkg::status_t          s1_status_q;
  logic                       s1_valid_q;
  logic                       out_valid_q;
  logic                       pop, s1_adv;

  assign s1_adv      = !out_valid_q || out_ready_i;
  assign cmd_ready_o = !s1_valid_q || s1_adv;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = out_valid_q;

  // Slot memory: at most one access per command, read data registered.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (cmd_i.op == rqwa_pkg::OP_ENQ) begin
        slot_q[cmd_addr_i] <= {cmd_i.client, cmd_i.amount - base_q};
      end else if (cmd_i.op == rqwa_pkg::OP_DEQ) begin
        rd_q <= slot_q[cmd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_op_q     <= cmd_i.op;
      s1_status_q <= cmd_i.status;
      s1_base_q   <= base_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Ageing every entry is one advance of the shared time base.
      if (pop && cmd_i.op == rqwa_pkg::OP_ADD) begin
        base_q <= base_q + cmd_i.amount;
      end
      if (cmd_ready_o) begin
        s1_valid_q <= cmd_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      ok_o       <= (s1_op_q != rqwa_pkg::OP_FAIL);
      count_o    <= s1_status_q.count;
      is_full_o  <= s1_status_q.full;
      is_empty_o <= s1_status_q.empty;
      if (s1_op_q == rqwa_pkg::OP_DEQ) begin
        out_client_id_o <= rd_q[EntryW-1:rqwa_pkg::WaitW];
        out_wait_o      <= rd_q[rqwa_pkg::WaitW-1:0] + s1_base_q;
      end else begin
        out_client_id_o <= '0;
        out_wait_o      <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/rqwa_checker.sv =====
// Port-level checks for the ring queue with wait aging, bound to the top.
// Depends on rqwa_pkg and ring_queue_with_wait_aging_top.
`timescale 1ns / 1ps

module rqwa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         ok_o,
  input logic [rqwa_pkg::ClientW-1:0] out_client_id_o,
  input logic [rqwa_pkg::WaitW-1:0]   out_wait_o,
  input logic [rqwa_pkg::CountW-1:0]  count_o,
  input logic                         is_full_o,
  input logic                         is_empty_o
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ok_o)
      && $stable(out_client_id_o) && $stable(out_wait_o) && $stable(count_o))
    else $error("result beat changed while stalled");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_full_o && is_empty_o))
    else $error("full and empty together");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> count_o == '0)
    else $error("empty with nonzero count");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> out_client_id_o == '0 && out_wait_o == '0)
    else $error("failed request returned data");

endmodule

bind ring_queue_with_wait_aging_top rqwa_checker u_rqwa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .ok_o           (ok_o),
  .out_client_id_o(out_client_id_o),
  .out_wait_o     (out_wait_o),
  .count_o        (count_o),
  .is_full_o      (is_full_o),
  .is_empty_o     (is_empty_o)
);
